/* hdl/bp2pal_pkg.sv */
package bp2pal_pkg;

    localparam int PLANE_COUNT  = 4;
    localparam int PLANE_BITS   = 8;
    localparam int PIXEL_COUNT  = PLANE_BITS;
    localparam int INDEX_BITS   = 4;
    localparam int ENTRY_COUNT  = 1 << INDEX_BITS;
    localparam int LEVEL_BITS   = 8;
    localparam int NIBBLE_BITS  = 4;
    localparam int RGB_BITS     = 3 * NIBBLE_BITS;
    localparam int ENTRY_BITS   = 16;
    localparam int GROUP_COUNT  = 4;
    localparam int GROUP_BITS   = 64;
    localparam int GROUP_ENTRIES = GROUP_BITS / ENTRY_BITS;

    localparam int IN_DATA_BITS   = PLANE_COUNT * PLANE_BITS;
    localparam int OUT_FIELD_BITS = INDEX_BITS + 4 * LEVEL_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int PIX_CNT_BITS   = $clog2(PIXEL_COUNT);

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GROUP_A = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GROUP_B = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GROUP_C = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GROUP_D = 3'd3;

    localparam logic [LEVEL_BITS-1:0] ALPHA_OPAQUE = 8'hff;

    typedef logic [IN_DATA_BITS-1:0] planes_t;

    typedef struct packed {
        logic                                fault;
        logic [ENTRY_COUNT-1:0][RGB_BITS-1:0] rgb;
    } pal_t;

    typedef struct packed {
        logic    valid;
        planes_t planes;
    } queue_out_t;

    // nibble times 17 is the nibble written twice
    function automatic logic [LEVEL_BITS-1:0] widen(input logic [NIBBLE_BITS-1:0] n);
        widen = {n, n};
    endfunction

endpackage

/* hdl/bitplane_to_palette_rgba_core.sv */
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    tdata: four plane bytes
// m_        out  m_tvalid/m_tready    tdata: index, rgba; tlast: last pixel; tuser: fault
// cfg_      in   cfg_we               cfg_index, cfg_wdata: palette groups a to d
//
// one plane word gives eight pixel words, one per cycle while the output register does not stall,
// set by the pixel serializer in the back part, which loads the next word as it sends the last pixel
// a two-word queue sits between input and serializer, so up to two words are taken
// while the serializer or the output register stalls; s_tready drops once both are full
// a taken word passes the queue and the plane register, and its first pixel the output register, on its way to m_
// reset is synchronous, active low; palette clears to zero
module bitplane_to_palette_rgba_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // plane_zero_byte, plane_one_byte, plane_two_byte, plane_three_byte
    input  logic [bp2pal_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // color_index, red_level, green_level, blue_level, alpha_level, zero pad
    output logic [bp2pal_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                   m_tlast,
    // palette_fault
    output logic                                   m_tuser,
    input  logic                                   cfg_we,
    input  logic [bp2pal_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bp2pal_pkg::GROUP_BITS-1:0]      cfg_wdata
);

    bp2pal_pkg::pal_t        pal;
    bp2pal_pkg::queue_out_t  q_out;
    logic                    q_pop;

    bp2pal_palette u_palette (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pal       (pal)
    );

    bp2pal_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_out    (q_out),
        .q_pop    (q_pop)
    );

    bp2pal_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_in     (q_out),
        .q_pop    (q_pop),
        .pal      (pal),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* hdl/bp2pal_palette.sv */
module bp2pal_palette (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [bp2pal_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bp2pal_pkg::GROUP_BITS-1:0]      cfg_wdata,
    output bp2pal_pkg::pal_t                       pal
);

    logic [bp2pal_pkg::ENTRY_COUNT-1:0][bp2pal_pkg::RGB_BITS-1:0] rgb_reg;
    logic [bp2pal_pkg::GROUP_COUNT-1:0]                           fault_reg;
    logic [bp2pal_pkg::GROUP_ENTRIES-1:0][bp2pal_pkg::RGB_BITS-1:0] wr_rgb;
    logic                                                         wr_fault;
    logic [bp2pal_pkg::GROUP_COUNT-1:0]                           wr_sel;

    always_comb begin
        wr_fault = 1'b0;
        for (int e = 0; e < bp2pal_pkg::GROUP_ENTRIES; e++) begin
            wr_rgb[e] = cfg_wdata[e*bp2pal_pkg::ENTRY_BITS +: bp2pal_pkg::RGB_BITS];
            wr_fault  = wr_fault |
                (|cfg_wdata[e*bp2pal_pkg::ENTRY_BITS + bp2pal_pkg::RGB_BITS +:
                            (bp2pal_pkg::ENTRY_BITS - bp2pal_pkg::RGB_BITS)]);
        end
    end

    always_comb begin
        wr_sel = '0;
        unique case (cfg_index)
            bp2pal_pkg::CFG_GROUP_A: wr_sel = 4'b0001;
            bp2pal_pkg::CFG_GROUP_B: wr_sel = 4'b0010;
            bp2pal_pkg::CFG_GROUP_C: wr_sel = 4'b0100;
            bp2pal_pkg::CFG_GROUP_D: wr_sel = 4'b1000;
            default:                 wr_sel = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rgb_reg   <= '0;
            fault_reg <= '0;
        end else if (cfg_we) begin
            for (int g = 0; g < bp2pal_pkg::GROUP_COUNT; g++) begin
                if (wr_sel[g]) begin
                    fault_reg[g] <= wr_fault;
                    for (int e = 0; e < bp2pal_pkg::GROUP_ENTRIES; e++) begin
                        rgb_reg[g*bp2pal_pkg::GROUP_ENTRIES + e] <= wr_rgb[e];
                    end
                end
            end
        end
    end

    assign pal.fault = |fault_reg;
    assign pal.rgb   = rgb_reg;

endmodule

/* hdl/bp2pal_front.sv */
module bp2pal_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  bp2pal_pkg::planes_t     s_tdata,
    output bp2pal_pkg::queue_out_t  q_out,
    input  logic                    q_pop
);

    bp2pal_pkg::planes_t                       entry_reg [bp2pal_pkg::QUEUE_DEPTH];
    logic [bp2pal_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bp2pal_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bp2pal_pkg::QUEUE_CNT_BITS-1:0]     count_reg, count_next;
    logic                                      push;
    logic                                      pop;

    assign s_tready = (count_reg != bp2pal_pkg::QUEUE_CNT_BITS'(bp2pal_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == bp2pal_pkg::QUEUE_PTR_BITS'(bp2pal_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == bp2pal_pkg::QUEUE_PTR_BITS'(bp2pal_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_tdata;
        end
    end

    assign q_out.valid  = (count_reg != '0);
    assign q_out.planes = entry_reg[rd_ptr_reg];

endmodule

/* hdl/bp2pal_back.sv */
module bp2pal_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bp2pal_pkg::queue_out_t                q_in,
    output logic                                  q_pop,
    input  bp2pal_pkg::pal_t                      pal,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bp2pal_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser
);

    logic [bp2pal_pkg::PLANE_COUNT-1:0][bp2pal_pkg::PLANE_BITS-1:0] planes_reg, planes_next;
    logic [bp2pal_pkg::PIX_CNT_BITS-1:0]   pix_cnt_reg, pix_cnt_next;
    logic                                  busy_reg, busy_next;
    logic                                  valid_reg, valid_next;
    logic [bp2pal_pkg::OUT_DATA_BITS-1:0]  data_reg, data_next;
    logic                                  last_reg, last_next;
    logic                                  fault_reg, fault_next;

    logic                                  out_free;
    logic                                  emit;
    logic                                  final_pix;
    logic [bp2pal_pkg::INDEX_BITS-1:0]     pix_index;
    logic [bp2pal_pkg::RGB_BITS-1:0]       pix_rgb;
    logic [bp2pal_pkg::LEVEL_BITS-1:0]     red, green, blue;

    assign out_free  = !valid_reg || m_tready;
    assign emit      = busy_reg && out_free;
    assign final_pix = (pix_cnt_reg == bp2pal_pkg::PIX_CNT_BITS'(bp2pal_pkg::PIXEL_COUNT - 1));
    assign q_pop     = (!busy_reg || (emit && final_pix)) && q_in.valid;

    // leftmost pixel sits in bit 7; planes shift left after each pixel
    always_comb begin
        for (int p = 0; p < bp2pal_pkg::PLANE_COUNT; p++) begin
            pix_index[p] = planes_reg[p][bp2pal_pkg::PLANE_BITS-1];
        end
    end

    assign pix_rgb = pal.rgb[pix_index];
    assign red   = pal.fault ? '0 : bp2pal_pkg::widen(pix_rgb[11:8]);
    assign green = pal.fault ? '0 : bp2pal_pkg::widen(pix_rgb[7:4]);
    assign blue  = pal.fault ? '0 : bp2pal_pkg::widen(pix_rgb[3:0]);

    always_comb begin
        planes_next  = planes_reg;
        pix_cnt_next = pix_cnt_reg;
        busy_next    = busy_reg;
        valid_next   = valid_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        fault_next   = fault_reg;

        if (m_tready) begin
            valid_next = 1'b0;
        end

        if (emit) begin
            valid_next   = 1'b1;
            data_next    = bp2pal_pkg::OUT_DATA_BITS'({bp2pal_pkg::ALPHA_OPAQUE,
                                                      blue, green, red, pix_index});
            last_next    = final_pix;
            fault_next   = pal.fault;
            pix_cnt_next = pix_cnt_reg + 1'b1;
            for (int p = 0; p < bp2pal_pkg::PLANE_COUNT; p++) begin
                planes_next[p] = {planes_reg[p][bp2pal_pkg::PLANE_BITS-2:0], 1'b0};
            end
            if (final_pix) begin
                busy_next = 1'b0;
            end
        end

        if (q_pop) begin
            planes_next  = q_in.planes;
            pix_cnt_next = '0;
            busy_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            pix_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            valid_reg   <= valid_next;
            pix_cnt_reg <= pix_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        planes_reg <= planes_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        fault_reg  <= fault_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = fault_reg;

endmodule
